// File: design/rti_pkg.sv
package rti_pkg;

    // component width and the widths that follow from it
    localparam int CB    = 21;
    localparam int FW    = 63;
    localparam int SW    = CB + 1;
    localparam int PW    = 2 * CB + 1;
    localparam int QW    = 2 * CB + 2;
    localparam int LW    = CB + 1;
    localparam int PPW   = SW + LW + 1;
    localparam int SUMW  = 3 * CB + 4;
    localparam int MW    = 3 * CB + 1;
    localparam int FRAC  = 16;
    localparam int QBITS = 2 * FRAC;
    localparam int IDXW  = 8;
    localparam int DATW  = 32;

    localparam int DOT_DET = 0;
    localparam int DOT_U   = 1;
    localparam int DOT_V   = 2;
    localparam int DOT_T   = 3;

    localparam logic [IDXW-1:0] REG_DET_EPS  = IDXW'(0);
    localparam logic [IDXW-1:0] REG_DIST_EPS = IDXW'(1);

    typedef logic signed [CB-1:0]   comp_t;
    typedef logic signed [SW-1:0]   scomp_t;
    typedef logic signed [2*CB-1:0] pprod_t;
    typedef logic signed [2*CB:0]   qprod_t;
    typedef logic signed [PW-1:0]   pvec_t;
    typedef logic signed [QW-1:0]   qvec_t;
    typedef logic signed [PPW-1:0]  part_t;
    typedef logic signed [SUMW-1:0] sum_t;
    typedef logic [MW-1:0]          mag_t;

    typedef struct packed {
        logic             cand;
        logic             sat;
        mag_t             rem;
        mag_t             den;
        logic [QBITS-1:0] bits;
    } rti_div_t;

    function automatic comp_t get_comp(input logic [FW-1:0] raw, input int idx);
        return raw[idx*CB +: CB];
    endfunction

endpackage

// File: design/rti_geom.sv
module rti_geom (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic [rti_pkg::FW-1:0]  ray_origin,
    input  logic [rti_pkg::FW-1:0]  ray_direction,
    input  logic [rti_pkg::FW-1:0]  vertex_zero,
    input  logic [rti_pkg::FW-1:0]  edge_one,
    input  logic [rti_pkg::FW-1:0]  edge_two,
    input  logic [31:0]             det_eps,
    output logic                    out_valid,
    output rti_pkg::rti_div_t       out_item
);
    import rti_pkg::*;

    // stage 1: unpack, s = origin - vertex, cross product terms
    logic   s1_valid_reg;
    comp_t  s1_d_reg [3];
    comp_t  s1_e1_reg [3];
    comp_t  s1_e2_reg [3];
    scomp_t s1_s_reg [3];
    pprod_t s1_pa_reg [3];
    pprod_t s1_pb_reg [3];
    qprod_t s1_qa_reg [3];
    qprod_t s1_qb_reg [3];

    comp_t  d_c [3];
    comp_t  e1_c [3];
    comp_t  e2_c [3];
    scomp_t s_c [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_c[i]  = get_comp(ray_direction, i);
            e1_c[i] = get_comp(edge_one, i);
            e2_c[i] = get_comp(edge_two, i);
            s_c[i]  = scomp_t'(get_comp(ray_origin, i)) - scomp_t'(get_comp(vertex_zero, i));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                s1_d_reg[i]  <= d_c[i];
                s1_e1_reg[i] <= e1_c[i];
                s1_e2_reg[i] <= e2_c[i];
                s1_s_reg[i]  <= s_c[i];
                s1_pa_reg[i] <= pprod_t'(d_c[(i+1)%3]) * pprod_t'(e2_c[(i+2)%3]);
                s1_pb_reg[i] <= pprod_t'(d_c[(i+2)%3]) * pprod_t'(e2_c[(i+1)%3]);
                s1_qa_reg[i] <= qprod_t'(s_c[(i+1)%3]) * qprod_t'(e1_c[(i+2)%3]);
                s1_qb_reg[i] <= qprod_t'(s_c[(i+2)%3]) * qprod_t'(e1_c[(i+1)%3]);
            end
        end
    end

    // stage 2: p = d x e2, q = s x e1
    logic   s2_valid_reg;
    comp_t  s2_d_reg [3];
    comp_t  s2_e1_reg [3];
    comp_t  s2_e2_reg [3];
    scomp_t s2_s_reg [3];
    pvec_t  s2_p_reg [3];
    qvec_t  s2_q_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                s2_d_reg[i]  <= s1_d_reg[i];
                s2_e1_reg[i] <= s1_e1_reg[i];
                s2_e2_reg[i] <= s1_e2_reg[i];
                s2_s_reg[i]  <= s1_s_reg[i];
                s2_p_reg[i]  <= pvec_t'(s1_pa_reg[i]) - pvec_t'(s1_pb_reg[i]);
                s2_q_reg[i]  <= qvec_t'(s1_qa_reg[i]) - qvec_t'(s1_qb_reg[i]);
            end
        end
    end

    // stage 3: partial products, wide factor split into low unsigned and high signed halves
    logic  s3_valid_reg;
    part_t s3_lo_reg [4][3];
    part_t s3_hi_reg [4][3];

    logic signed [LW:0]      p_lo [3];
    logic signed [LW:0]      q_lo [3];
    logic signed [PW-LW-1:0] p_hi [3];
    logic signed [QW-LW-1:0] q_hi [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p_lo[i] = $signed({1'b0, s2_p_reg[i][LW-1:0]});
            q_lo[i] = $signed({1'b0, s2_q_reg[i][LW-1:0]});
            p_hi[i] = s2_p_reg[i][PW-1:LW];
            q_hi[i] = s2_q_reg[i][QW-1:LW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                s3_lo_reg[DOT_DET][i] <= part_t'(s2_e1_reg[i]) * part_t'(p_lo[i]);
                s3_hi_reg[DOT_DET][i] <= part_t'(s2_e1_reg[i]) * part_t'(p_hi[i]);
                s3_lo_reg[DOT_U][i]   <= part_t'(s2_s_reg[i]) * part_t'(p_lo[i]);
                s3_hi_reg[DOT_U][i]   <= part_t'(s2_s_reg[i]) * part_t'(p_hi[i]);
                s3_lo_reg[DOT_V][i]   <= part_t'(s2_d_reg[i]) * part_t'(q_lo[i]);
                s3_hi_reg[DOT_V][i]   <= part_t'(s2_d_reg[i]) * part_t'(q_hi[i]);
                s3_lo_reg[DOT_T][i]   <= part_t'(s2_e2_reg[i]) * part_t'(q_lo[i]);
                s3_hi_reg[DOT_T][i]   <= part_t'(s2_e2_reg[i]) * part_t'(q_hi[i]);
            end
        end
    end

    // stage 4: recombine halves into full products
    logic s4_valid_reg;
    sum_t s4_prod_reg [4][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (adv) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                for (int i = 0; i < 3; i++) begin
                    s4_prod_reg[k][i] <= (sum_t'(s3_hi_reg[k][i]) <<< LW)
                                         + sum_t'(s3_lo_reg[k][i]);
                end
            end
        end
    end

    // stage 5: dot product sums
    logic s5_valid_reg;
    sum_t s5_dot_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
        end else if (adv) begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                s5_dot_reg[k] <= s4_prod_reg[k][0] + s4_prod_reg[k][1] + s4_prod_reg[k][2];
            end
        end
    end

    // stage 6: sign and magnitude
    logic s6_valid_reg;
    logic s6_neg_reg [4];
    mag_t s6_mag_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_valid_reg <= 1'b0;
        end else if (adv) begin
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                s6_neg_reg[k] <= s5_dot_reg[k][SUMW-1];
                s6_mag_reg[k] <= s5_dot_reg[k][SUMW-1] ? mag_t'(-s5_dot_reg[k])
                                                        : mag_t'(s5_dot_reg[k]);
            end
        end
    end

    // stage 7: bounds tests and divider setup
    logic     s7_valid_reg;
    rti_div_t s7_item_reg;
    rti_div_t item_next;
    logic     miss;
    logic [MW:0] uv_sum;

    always_comb begin
        uv_sum = {1'b0, s6_mag_reg[DOT_U]} + {1'b0, s6_mag_reg[DOT_V]};
        miss = (s6_mag_reg[DOT_DET] == '0)
            || (s6_mag_reg[DOT_DET] < mag_t'(det_eps))
            || ((s6_neg_reg[DOT_U] != s6_neg_reg[DOT_DET]) && (s6_mag_reg[DOT_U] != '0))
            || (s6_mag_reg[DOT_U] > s6_mag_reg[DOT_DET])
            || ((s6_neg_reg[DOT_V] != s6_neg_reg[DOT_DET]) && (s6_mag_reg[DOT_V] != '0))
            || (uv_sum > {1'b0, s6_mag_reg[DOT_DET]})
            || (s6_neg_reg[DOT_T] != s6_neg_reg[DOT_DET])
            || (s6_mag_reg[DOT_T] == '0);
        item_next.cand = !miss;
        item_next.rem  = s6_mag_reg[DOT_T] >> FRAC;
        item_next.sat  = (s6_mag_reg[DOT_T] >> FRAC) >= s6_mag_reg[DOT_DET];
        item_next.den  = s6_mag_reg[DOT_DET];
        item_next.bits = {s6_mag_reg[DOT_T][FRAC-1:0], {FRAC{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s7_valid_reg <= 1'b0;
        end else if (adv) begin
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s7_item_reg <= item_next;
        end
    end

    assign out_valid = s7_valid_reg;
    assign out_item  = s7_item_reg;

endmodule

// File: design/rti_div.sv
module rti_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  rti_pkg::rti_div_t in_item,
    output logic              out_valid,
    output rti_pkg::rti_div_t out_item
);
    import rti_pkg::*;

    // one restoring step per stage, quotient bits shift in where dividend bits leave
    logic     vld_reg [QBITS];
    rti_div_t st_reg [QBITS];

    for (genvar j = 0; j < QBITS; j++) begin : g_step
        logic     prev_valid;
        rti_div_t prev;
        rti_div_t step_next;
        logic [MW:0] r2;
        logic        ge;

        if (j == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev       = in_item;
        end else begin : g_rest
            assign prev_valid = vld_reg[j-1];
            assign prev       = st_reg[j-1];
        end

        always_comb begin
            r2 = {prev.rem, prev.bits[QBITS-1]};
            ge = r2 >= {1'b0, prev.den};
            step_next      = prev;
            step_next.rem  = ge ? mag_t'(r2 - {1'b0, prev.den}) : mag_t'(r2);
            step_next.bits = {prev.bits[QBITS-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (adv) begin
                vld_reg[j] <= prev_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                st_reg[j] <= step_next;
            end
        end
    end

    assign out_valid = vld_reg[QBITS-1];
    assign out_item  = st_reg[QBITS-1];

endmodule

// File: design/ray_triangle_intersect.sv
// pipeline: 7 geometry stages, 32 divider stages and 1 output register lie between
// the accepted input word and the output word
// throughput: one word per cycle; the whole pipeline advances together and holds
// while the output word waits
// reset: synchronous, active low; clears all valid bits, det_epsilon and
// distance_epsilon return to 1
module ray_triangle_intersect (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // ray_origin, ray_direction, vertex_zero, edge_one, edge_two, 63 bits each
    input  logic [319:0]             s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // distance
    output logic [31:0]              m_tdata,
    // hit
    output logic                     m_tuser,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [rti_pkg::IDXW-1:0] cfg_index,
    input  logic [rti_pkg::DATW-1:0] cfg_data
);
    import rti_pkg::*;

    logic [DATW-1:0] det_eps_reg;
    logic [DATW-1:0] dist_eps_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            det_eps_reg  <= DATW'(1);
            dist_eps_reg <= DATW'(1);
        end else if (cfg_valid) begin
            if (cfg_index == REG_DET_EPS) begin
                det_eps_reg <= cfg_data;
            end
            if (cfg_index == REG_DIST_EPS) begin
                dist_eps_reg <= cfg_data;
            end
        end
    end

    logic adv;
    logic m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic m_tuser_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    logic     geom_valid;
    rti_div_t geom_item;
    logic     div_valid;
    rti_div_t div_item;

    rti_geom u_geom (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .in_valid      (s_tvalid),
        .ray_origin    (s_tdata[62:0]),
        .ray_direction (s_tdata[125:63]),
        .vertex_zero   (s_tdata[188:126]),
        .edge_one      (s_tdata[251:189]),
        .edge_two      (s_tdata[314:252]),
        .det_eps       (det_eps_reg),
        .out_valid     (geom_valid),
        .out_item      (geom_item)
    );

    rti_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (geom_valid),
        .in_item   (geom_item),
        .out_valid (div_valid),
        .out_item  (div_item)
    );

    logic [QBITS-1:0] tq;
    logic             hit_next;

    always_comb begin
        tq       = div_item.sat ? {QBITS{1'b1}} : div_item.bits;
        hit_next = div_item.cand && (tq > dist_eps_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tuser_reg <= hit_next;
            m_tdata_reg <= hit_next ? tq : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a miss carries zero distance
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss word with nonzero distance");

    // a hit lies strictly beyond the distance epsilon
    a_hit_eps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata > dist_eps_reg)
        else $error("hit word not beyond distance epsilon");

    // a blocked output stalls the input side
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // a stalled pipeline keeps its output word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed under stall");

endmodule

// File: sim/tb_ray_triangle_intersect.sv
module tb_ray_triangle_intersect;
    import rti_pkg::*;

    localparam int  FIELD_BITS = 63;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  DRAIN_CYCLES = 45;
    localparam int  ONE = 2048;   // 1.0 in Q10.11
    localparam logic [IDXW-1:0] REG_SPARE = IDXW'(7);

    typedef logic signed [127:0] wide_t;
    typedef longint vec3_t [3];

    typedef struct packed {
        logic        hit;
        logic [31:0] distance;
    } hit_t;

    typedef struct {
        logic [319:0] word;
        bit           known;
        hit_t         want;
    } row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [319:0]        s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;
    logic                m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDXW-1:0]     cfg_index = '0;
    logic [DATW-1:0]     cfg_data = '0;

    logic [31:0] det_eps_now = 32'd1;
    logic [31:0] dist_eps_now = 32'd1;
    hit_t        pending_hits[$];
    bit          tx_idle = 0;
    bit          rx_stall = 0;
    int          idle_pct = 87;
    int          errors = 0;
    int          cycles = 0;

    ray_triangle_intersect dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL ray_triangle_intersect");
            $finish;
        end
    end

    always @(negedge aclk)
        m_tready = rx_stall ? ($urandom_range(99) >= idle_pct) : 1'b1;

    // result checker
    always @(posedge aclk) begin
        hit_t exp_hit;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_hits.size() == 0) begin
                errors++;
                $display("%0t: unexpected word hit=%0b distance=%h", $time, m_tuser, m_tdata);
            end else begin
                exp_hit = pending_hits.pop_front();
                if (m_tuser !== exp_hit.hit) begin
                    errors++;
                    $display("%0t: hit expected %0b actual %0b", $time, exp_hit.hit, m_tuser);
                end
                if (m_tdata !== exp_hit.distance) begin
                    errors++;
                    $display("%0t: distance expected %h actual %h",
                             $time, exp_hit.distance, m_tdata);
                end
            end
        end
    end

    function automatic logic [62:0] vec(longint x, longint y, longint z);
        return {z[CB-1:0], y[CB-1:0], x[CB-1:0]};
    endfunction

    function automatic logic [319:0] pack_word(logic [62:0] org, logic [62:0] dir,
                                               logic [62:0] v0, logic [62:0] e1,
                                               logic [62:0] e2);
        return {5'b0, e2, e1, v0, dir, org};
    endfunction

    function automatic vec3_t field_vec(logic [319:0] w, int f);
        vec3_t r;
        comp_t c;
        for (int i = 0; i < 3; i++) begin
            c = w[f*FIELD_BITS + i*CB +: CB];
            r[i] = longint'(c);
        end
        return r;
    endfunction

    function automatic vec3_t cross_prod(vec3_t a, vec3_t b);
        vec3_t c;
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        return c;
    endfunction

    function automatic wide_t dot(vec3_t a, vec3_t b);
        wide_t acc;
        acc = 0;
        for (int i = 0; i < 3; i++)
            acc += wide_t'(a[i]) * wide_t'(b[i]);
        return acc;
    endfunction

    function automatic wide_t magnitude(wide_t x);
        return (x < 0) ? -x : x;
    endfunction

    // exact moller-trumbore on the integer grid, all numerators share the det scale
    function automatic hit_t predict(logic [319:0] w);
        vec3_t org, dir, v0, e1, e2, s, p, q;
        wide_t det, u, v, t, dmag, umag, vmag, tq;
        bit    dneg;
        hit_t  r;
        r = '0;
        org = field_vec(w, 0);
        dir = field_vec(w, 1);
        v0  = field_vec(w, 2);
        e1  = field_vec(w, 3);
        e2  = field_vec(w, 4);
        p = cross_prod(dir, e2);
        det = dot(e1, p);
        dmag = magnitude(det);
        dneg = det < 0;
        if (det == 0 || dmag < wide_t'(det_eps_now))
            return r;
        for (int i = 0; i < 3; i++)
            s[i] = org[i] - v0[i];
        u = dot(s, p);
        umag = magnitude(u);
        if ((u != 0 && ((u < 0) != dneg)) || umag > dmag)
            return r;
        q = cross_prod(s, e1);
        v = dot(dir, q);
        vmag = magnitude(v);
        if ((v != 0 && ((v < 0) != dneg)) || umag + vmag > dmag)
            return r;
        t = dot(e2, q);
        if (t == 0 || ((t < 0) != dneg))
            return r;
        tq = (magnitude(t) <<< 16) / dmag;
        if (tq > wide_t'(32'hFFFF_FFFF))
            tq = wide_t'(32'hFFFF_FFFF);
        if (tq > wide_t'(dist_eps_now)) begin
            r.hit = 1'b1;
            r.distance = tq[31:0];
        end
        return r;
    endfunction

    task automatic send_word(logic [319:0] w);
        while (tx_idle && $urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = w;
        do @(posedge aclk); while (!s_tready);
        pending_hits.push_back(predict(w));
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [IDXW-1:0] idx, logic [DATW-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_DET_EPS)
            det_eps_now = value;
        else if (idx == REG_DIST_EPS)
            dist_eps_now = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending_hits.size() > 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic longint rnd(int span);
        return longint'($urandom_range(2 * span)) - span;
    endfunction

    // random word: mostly rays aimed at a point inside the triangle
    function automatic logic [319:0] random_word();
        vec3_t v0, e1, e2, org, dir;
        int    a, b, k, pick;
        pick = $urandom_range(99);
        for (int i = 0; i < 3; i++) begin
            v0[i] = rnd(1 << 14);
            e1[i] = rnd(1 << 14);
            e2[i] = rnd(1 << 14);
            org[i] = rnd(1 << 14);
        end
        if (pick < 20)
            return pack_word(63'({$urandom, $urandom}), 63'({$urandom, $urandom}),
                             63'({$urandom, $urandom}), 63'({$urandom, $urandom}),
                             63'({$urandom, $urandom}));
        if (pick < 30) begin
            // direction in the triangle plane
            for (int i = 0; i < 3; i++)
                dir[i] = e1[i] + e2[i];
        end else begin
            a = $urandom_range(256);
            b = $urandom_range(256 - a);
            if (pick < 40) a = 0;
            k = $urandom_range(4);
            for (int i = 0; i < 3; i++)
                dir[i] = (v0[i] + (a * e1[i] + b * e2[i]) / 256 - org[i]) >>> k;
            if (pick < 50)
                for (int i = 0; i < 3; i++)
                    dir[i] = -dir[i];
        end
        return pack_word(vec(org[0], org[1], org[2]), vec(dir[0], dir[1], dir[2]),
                         vec(v0[0], v0[1], v0[2]), vec(e1[0], e1[1], e1[2]),
                         vec(e2[0], e2[1], e2[2]));
    endfunction

    initial begin
        row_t  rows[$];
        hit_t  got;
        logic [62:0] zv, e1x, e2y, maxp, minn;
        logic [31:0] phase_det[6];
        logic [31:0] phase_dist[6];
        int          phase_mode[6];

        zv = vec(0, 0, 0);
        e1x = vec(ONE, 0, 0);
        e2y = vec(0, ONE, 0);
        maxp = vec((1 << 20) - 1, (1 << 20) - 1, (1 << 20) - 1);
        minn = vec(-(1 << 20), -(1 << 20), -(1 << 20));

        rows.push_back('{pack_word(zv, zv, zv, zv, zv), 1, '{1'b0, 32'd0}});
        rows.push_back('{{5'b0, {315{1'b1}}}, 1, '{1'b0, 32'd0}});
        rows.push_back('{pack_word(maxp, maxp, maxp, maxp, maxp), 1, '{1'b0, 32'd0}});
        rows.push_back('{pack_word(minn, minn, minn, minn, minn), 1, '{1'b0, 32'd0}});
        // straight down onto the unit triangle at distance one
        rows.push_back('{pack_word(vec(512, 512, ONE), vec(0, 0, -ONE), zv, e1x, e2y),
                         1, '{1'b1, 32'h0001_0000}});
        // pointing away
        rows.push_back('{pack_word(vec(512, 512, ONE), vec(0, 0, ONE), zv, e1x, e2y),
                         1, '{1'b0, 32'd0}});
        // parallel to the plane
        rows.push_back('{pack_word(vec(512, 512, ONE), vec(ONE, 0, 0), zv, e1x, e2y),
                         1, '{1'b0, 32'd0}});
        // far away, distance saturates
        rows.push_back('{pack_word(vec(512, 512, 1 << 19), vec(0, 0, -1), zv, e1x, e2y),
                         1, '{1'b1, 32'hFFFF_FFFF}});
        // origin on the plane: zero distance
        rows.push_back('{pack_word(vec(512, 512, 0), vec(0, 0, -ONE), zv, e1x, e2y),
                         1, '{1'b0, 32'd0}});
        // on the edges and corners, and just outside
        rows.push_back('{pack_word(vec(0, 512, ONE), vec(0, 0, -ONE), zv, e1x, e2y), 0, '0});
        rows.push_back('{pack_word(vec(512, 0, ONE), vec(0, 0, -ONE), zv, e1x, e2y), 0, '0});
        rows.push_back('{pack_word(vec(1024, 1024, ONE), vec(0, 0, -ONE), zv, e1x, e2y),
                         0, '0});
        rows.push_back('{pack_word(vec(ONE, 0, ONE), vec(0, 0, -ONE), zv, e1x, e2y), 0, '0});
        rows.push_back('{pack_word(vec(1025, 1024, ONE), vec(0, 0, -ONE), zv, e1x, e2y),
                         0, '0});
        rows.push_back('{pack_word(vec(-1, 512, ONE), vec(0, 0, -ONE), zv, e1x, e2y), 0, '0});
        rows.push_back('{pack_word(vec(512, -1, ONE), vec(0, 0, -ONE), zv, e1x, e2y), 0, '0});
        // flipped winding gives a negative determinant
        rows.push_back('{pack_word(vec(512, 512, ONE), vec(0, 0, -ONE), zv, e2y, e1x), 0, '0});
        rows.push_back('{pack_word(vec(300, 700, -5000), vec(3, -7, 4096), vec(100, 100, 0),
                                   e1x, e2y), 0, '0});

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[i]) begin
            if (rows[i].known) begin
                got = predict(rows[i].word);
                if (got !== rows[i].want) begin
                    errors++;
                    $display("%0t: row %0d table expects %h predictor gives %h",
                             $time, i, rows[i].want, got);
                end
            end
            send_word(rows[i].word);
        end
        drain();

        phase_det = '{32'd1, 32'd0, 32'hFFFF_FFFF, $urandom_range(1 << 20), 32'd1, 32'd1 << 24};
        phase_dist = '{32'd1, 32'd0, 32'hFFFF_FFFF, $urandom_range(1 << 18), 32'h0001_0000,
                       32'd1};
        phase_mode = '{0, 1, 2, 3, 0, 3};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_DET_EPS, phase_det[ph]);
            write_reg(REG_DIST_EPS, phase_dist[ph]);
            if (ph == 4)
                write_reg(REG_SPARE, $urandom);
            // both sides idle at a lighter rate than either alone
            idle_pct = (phase_mode[ph] == 3) ? 28 : 87;
            tx_idle = (phase_mode[ph] == 1) || (phase_mode[ph] == 3);
            rx_stall = (phase_mode[ph] == 2) || (phase_mode[ph] == 3);
            for (int n = 0; n < 285; n++) begin
                // stretches with no idling inside the idle phases
                if (phase_mode[ph] != 0 && n % 100 == 50) begin
                    tx_idle = 0;
                    rx_stall = 0;
                end
                if (phase_mode[ph] != 0 && n % 100 == 70) begin
                    tx_idle = (phase_mode[ph] == 1) || (phase_mode[ph] == 3);
                    rx_stall = (phase_mode[ph] == 2) || (phase_mode[ph] == 3);
                end
                send_word(random_word());
            end
            drain();
            tx_idle = 0;
            rx_stall = 0;
        end

        if (errors == 0)
            $display("PASS ray_triangle_intersect");
        else
            $display("FAIL ray_triangle_intersect");
        $finish;
    end

endmodule
